[rtl/core/quadratic_real_root_solver_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic real-root solver.
// Checks are compiled for simulation and vanish for synthesis.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_REAL_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_REAL_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs assertion failed");
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMP(lbl, ante, cons)
`define QRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, case codes and coefficient flags of the root solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [2:0] CASE_IDENTITY      = 3'd0;
    localparam logic [2:0] CASE_CONTRADICTION = 3'd1;
    localparam logic [2:0] CASE_LINEAR        = 3'd2;
    localparam logic [2:0] CASE_NO_ROOT       = 3'd3;
    localparam logic [2:0] CASE_DOUBLE        = 3'd4;
    localparam logic [2:0] CASE_TWO           = 3'd5;

    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic c_neg;
        logic a_zero;
        logic b_zero;
        logic c_zero;
    } coef_flags_t;

endpackage

[rtl/core/qrs_mul_cell.sv]
// ----------------------------------------------------------------------------
// qrs_mul_cell
// One shift-add step of the b*b and a*c products; adds at most one partial product to each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_mul_cell
    import qrs_pkg::*;
#(
    parameter int W   = WORD_BITS_DEF,
    parameter int POS = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  logic [W-1:0]     ma_in,
    input  logic [W-1:0]     mb_in,
    input  logic [W-1:0]     mc_in,
    input  logic [2*W-1:0]   bb_in,
    input  logic [2*W-1:0]   ac_in,
    input  coef_flags_t      flags_in,
    output logic             dn_valid,
    input  logic             dn_stall,
    output logic [W-1:0]     ma_out,
    output logic [W-1:0]     mb_out,
    output logic [W-1:0]     mc_out,
    output logic [2*W-1:0]   bb_out,
    output logic [2*W-1:0]   ac_out,
    output coef_flags_t      flags_out
);

    logic             valid_reg;
    logic [W-1:0]     ma_reg, mb_reg, mc_reg;
    logic [2*W-1:0]   bb_reg, ac_reg, bb_next, ac_next;
    logic [2*W-1:0]   b_part, a_part;
    coef_flags_t      flags_reg;
    logic             accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    always_comb
    begin
        b_part  = {{W{1'b0}}, mb_in} << POS;
        a_part  = {{W{1'b0}}, ma_in} << POS;
        bb_next = mb_in[POS] ? bb_in + b_part : bb_in;
        ac_next = mc_in[POS] ? ac_in + a_part : ac_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ma_reg    <= ma_in;
            mb_reg    <= mb_in;
            mc_reg    <= mc_in;
            bb_reg    <= bb_next;
            ac_reg    <= ac_next;
            flags_reg <= flags_in;
        end
    end

    assign dn_valid  = valid_reg;
    assign ma_out    = ma_reg;
    assign mb_out    = mb_reg;
    assign mc_out    = mc_reg;
    assign bb_out    = bb_reg;
    assign ac_out    = ac_reg;
    assign flags_out = flags_reg;

endmodule

[rtl/core/qrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the integer square root, from the top power of four downward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_sqrt_cell
#(
    parameter int DW      = 66,
    parameter int SW      = 8,
    parameter int BIT_POS = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  logic [DW-1:0] x_in,
    input  logic [DW-1:0] res_in,
    input  logic [SW-1:0] side_in,
    output logic          dn_valid,
    input  logic          dn_stall,
    output logic [DW-1:0] x_out,
    output logic [DW-1:0] res_out,
    output logic [SW-1:0] side_out
);

    logic          valid_reg;
    logic [DW-1:0] x_reg, res_reg, x_next, res_next;
    logic [SW-1:0] side_reg;
    logic [DW-1:0] bitv, trial;
    logic [DW:0]   diff;
    logic          accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    always_comb
    begin
        bitv  = {{(DW-1){1'b0}}, 1'b1} << BIT_POS;
        trial = res_in + bitv;
        diff  = {1'b0, x_in} - {1'b0, trial};
        if (!diff[DW])
        begin
            x_next   = diff[DW-1:0];
            res_next = (res_in >> 1) + bitv;
        end
        else
        begin
            x_next   = x_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x_next;
            res_reg  <= res_next;
            side_reg <= side_in;
        end
    end

    assign dn_valid = valid_reg;
    assign x_out    = x_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule

[rtl/core/qrs_div_cell.sv]
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step for both root lanes over a shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_div_cell
#(
    parameter int NW  = 49,
    parameter int DNW = 33,
    parameter int SW  = 5
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_stall,
    input  logic [DNW-1:0] den_in,
    input  logic [DNW-1:0] rem1_in,
    input  logic [DNW-1:0] rem2_in,
    input  logic [NW-1:0]  nq1_in,
    input  logic [NW-1:0]  nq2_in,
    input  logic [SW-1:0]  side_in,
    output logic           dn_valid,
    input  logic           dn_stall,
    output logic [DNW-1:0] den_out,
    output logic [DNW-1:0] rem1_out,
    output logic [DNW-1:0] rem2_out,
    output logic [NW-1:0]  nq1_out,
    output logic [NW-1:0]  nq2_out,
    output logic [SW-1:0]  side_out
);

    logic           valid_reg;
    logic [DNW-1:0] den_reg, rem1_reg, rem2_reg, rem1_next, rem2_next;
    logic [NW-1:0]  nq1_reg, nq2_reg, nq1_next, nq2_next;
    logic [SW-1:0]  side_reg;
    logic [DNW:0]   t1, t2;
    logic [DNW+1:0] d1, d2;
    logic           accept;

    assign up_stall = valid_reg && dn_stall;
    assign accept   = up_valid && !up_stall;

    // The dividend bits leave the top of nq while the quotient bits enter at the bottom.
    always_comb
    begin
        t1        = {rem1_in, nq1_in[NW-1]};
        t2        = {rem2_in, nq2_in[NW-1]};
        d1        = {1'b0, t1} - {2'b00, den_in};
        d2        = {1'b0, t2} - {2'b00, den_in};
        rem1_next = !d1[DNW+1] ? d1[DNW-1:0] : t1[DNW-1:0];
        rem2_next = !d2[DNW+1] ? d2[DNW-1:0] : t2[DNW-1:0];
        nq1_next  = {nq1_in[NW-2:0], !d1[DNW+1]};
        nq2_next  = {nq2_in[NW-2:0], !d2[DNW+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            den_reg  <= den_in;
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
            nq1_reg  <= nq1_next;
            nq2_reg  <= nq2_next;
            side_reg <= side_in;
        end
    end

    assign dn_valid = valid_reg;
    assign den_out  = den_reg;
    assign rem1_out = rem1_reg;
    assign rem2_out = rem2_reg;
    assign nq1_out  = nq1_reg;
    assign nq2_out  = nq2_reg;
    assign side_out = side_reg;

endmodule

[rtl/core/quadratic_real_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_real_root_solver
// Pipeline: one cell per product bit, per root digit and per quotient bit,
// plus three registers for the discriminant, the quotient setup and the result.
// Throughput is one coefficient set per cycle while root_stall is low; a cell
// holds its data while it is full and the cell below it stalls.
// Reset clears only the valid bits of the cells; the data needs none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadratic_real_root_solver_defines.svh"

module quadratic_real_root_solver
    import qrs_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        coef_valid,
    output logic                        coef_stall,
    input  logic signed [WORD_BITS-1:0] coef_a,
    input  logic signed [WORD_BITS-1:0] coef_b,
    input  logic signed [WORD_BITS-1:0] coef_c,
    output logic                        root_valid,
    input  logic                        root_stall,
    output logic [2:0]                  root_case,
    output logic signed [WORD_BITS-1:0] root_one,
    output logic signed [WORD_BITS-1:0] root_two,
    output logic                        saturated
);

    localparam int W     = WORD_BITS;
    localparam int DW    = 2 * W + 2;
    localparam int K     = W + 1;
    localparam int NUMW  = W + 1;
    localparam int NW    = NUMW + FRAC_BITS;
    localparam int DNW   = W + 1;
    localparam int PW    = W + 3;
    localparam int SQ_SW = 3 * W + $bits(coef_flags_t) + 1;
    localparam int DV_SW = 5;

    // Product chain.
    logic              m_valid [0:W];
    logic              m_stall [0:W];
    logic [W-1:0]      m_ma    [0:W];
    logic [W-1:0]      m_mb    [0:W];
    logic [W-1:0]      m_mc    [0:W];
    logic [2*W-1:0]    m_bb    [0:W];
    logic [2*W-1:0]    m_ac    [0:W];
    coef_flags_t       m_flags [0:W];

    assign m_valid[0] = coef_valid;
    assign coef_stall = m_stall[0];
    assign m_ma[0]    = coef_a[W-1] ? -coef_a : coef_a;
    assign m_mb[0]    = coef_b[W-1] ? -coef_b : coef_b;
    assign m_mc[0]    = coef_c[W-1] ? -coef_c : coef_c;
    assign m_bb[0]    = '0;
    assign m_ac[0]    = '0;
    assign m_flags[0] = '{a_neg: coef_a[W-1], b_neg: coef_b[W-1], c_neg: coef_c[W-1],
                          a_zero: (coef_a == '0), b_zero: (coef_b == '0),
                          c_zero: (coef_c == '0)};

    for (genvar i = 0; i < W; i++)
    begin : g_mul
        qrs_mul_cell #(.W(W), .POS(i)) u_cell
        (
            .clk(clk), .rst_n(rst_n),
            .up_valid(m_valid[i]), .up_stall(m_stall[i]),
            .ma_in(m_ma[i]), .mb_in(m_mb[i]), .mc_in(m_mc[i]),
            .bb_in(m_bb[i]), .ac_in(m_ac[i]), .flags_in(m_flags[i]),
            .dn_valid(m_valid[i+1]), .dn_stall(m_stall[i+1]),
            .ma_out(m_ma[i+1]), .mb_out(m_mb[i+1]), .mc_out(m_mc[i+1]),
            .bb_out(m_bb[i+1]), .ac_out(m_ac[i+1]), .flags_out(m_flags[i+1])
        );
    end

    // Discriminant register: |b*b - 4ac| and its sign.
    logic              s_valid [0:K];
    logic              s_stall [0:K];
    logic [DW-1:0]     s_x     [0:K];
    logic [DW-1:0]     s_res   [0:K];
    logic [SQ_SW-1:0]  s_side  [0:K];

    logic              disc_valid_reg;
    logic [DW-1:0]     disc_reg, disc_next;
    logic [SQ_SW-1:0]  disc_side_reg;
    logic [DW-1:0]     ac4, bbx;
    logic [DW:0]       ddiff;
    logic              acneg, neg_disc_next;

    always_comb
    begin
        ac4   = {m_ac[W], 2'b00};
        bbx   = {2'b00, m_bb[W]};
        ddiff = {1'b0, bbx} - {1'b0, ac4};
        acneg = (m_flags[W].a_neg ^ m_flags[W].c_neg) && !m_flags[W].c_zero;
        neg_disc_next = !acneg && ddiff[DW];
        if (acneg)
        begin
            disc_next = bbx + ac4;
        end
        else if (ddiff[DW])
        begin
            disc_next = -ddiff[DW-1:0];
        end
        else
        begin
            disc_next = ddiff[DW-1:0];
        end
    end

    assign m_stall[W] = disc_valid_reg && s_stall[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_valid_reg <= 1'b0;
        end
        else if (!m_stall[W])
        begin
            disc_valid_reg <= m_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid[W] && !m_stall[W])
        begin
            disc_reg      <= disc_next;
            disc_side_reg <= {m_ma[W], m_mb[W], m_mc[W], m_flags[W], neg_disc_next};
        end
    end

    // Square root chain.
    assign s_valid[0] = disc_valid_reg;
    assign s_x[0]     = disc_reg;
    assign s_res[0]   = '0;
    assign s_side[0]  = disc_side_reg;

    for (genvar j = 0; j < K; j++)
    begin : g_sqrt
        qrs_sqrt_cell #(.DW(DW), .SW(SQ_SW), .BIT_POS(2 * (K - 1 - j))) u_cell
        (
            .clk(clk), .rst_n(rst_n),
            .up_valid(s_valid[j]), .up_stall(s_stall[j]),
            .x_in(s_x[j]), .res_in(s_res[j]), .side_in(s_side[j]),
            .dn_valid(s_valid[j+1]), .dn_stall(s_stall[j+1]),
            .x_out(s_x[j+1]), .res_out(s_res[j+1]), .side_out(s_side[j+1])
        );
    end

    // Quotient setup: numerators, divisor and signs for both lanes.
    logic              d_valid [0:NW];
    logic              d_stall [0:NW];
    logic [DNW-1:0]    d_den   [0:NW];
    logic [DNW-1:0]    d_rem1  [0:NW];
    logic [DNW-1:0]    d_rem2  [0:NW];
    logic [NW-1:0]     d_nq1   [0:NW];
    logic [NW-1:0]     d_nq2   [0:NW];
    logic [DV_SW-1:0]  d_side  [0:NW];

    logic [W-1:0]      p_ma, p_mb, p_mc;
    coef_flags_t       p_flags;
    logic              p_negd;
    logic [W:0]        p_root;
    logic [PW-1:0]     nb, sx, n1, n2, a1, a2;
    logic [NUMW-1:0]   mag1, mag2;
    logic [DNW-1:0]    den_next;
    logic              neg1_next, neg2_next;
    logic [2:0]        case_next;

    logic              prep_valid_reg;
    logic [DNW-1:0]    prep_den_reg;
    logic [NW-1:0]     prep_nq1_reg, prep_nq2_reg;
    logic [DV_SW-1:0]  prep_side_reg;

    assign {p_ma, p_mb, p_mc, p_flags, p_negd} = s_side[K];
    assign p_root = s_res[K][W:0];

    always_comb
    begin
        nb = p_flags.b_neg ? {3'b000, p_mb} : -{3'b000, p_mb};
        sx = {2'b00, p_root};
        n1 = nb + sx;
        n2 = nb - sx;
        a1 = n1[PW-1] ? -n1 : n1;
        a2 = n2[PW-1] ? -n2 : n2;
        if (p_flags.a_zero)
        begin
            mag1      = {1'b0, p_mc};
            mag2      = {1'b0, p_mc};
            den_next  = {1'b0, p_mb};
            neg1_next = (!p_flags.c_neg && !p_flags.c_zero) ^ p_flags.b_neg;
            neg2_next = neg1_next;
            if (!p_flags.b_zero)
            begin
                case_next = CASE_LINEAR;
            end
            else if (p_flags.c_zero)
            begin
                case_next = CASE_IDENTITY;
            end
            else
            begin
                case_next = CASE_CONTRADICTION;
            end
        end
        else
        begin
            mag1      = a1[NUMW-1:0];
            mag2      = a2[NUMW-1:0];
            den_next  = {p_ma, 1'b0};
            neg1_next = n1[PW-1] ^ p_flags.a_neg;
            neg2_next = n2[PW-1] ^ p_flags.a_neg;
            if (p_negd)
            begin
                case_next = CASE_NO_ROOT;
            end
            else if (p_root == '0)
            begin
                case_next = CASE_DOUBLE;
            end
            else
            begin
                case_next = CASE_TWO;
            end
        end
    end

    assign s_stall[K] = prep_valid_reg && d_stall[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (!s_stall[K])
        begin
            prep_valid_reg <= s_valid[K];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid[K] && !s_stall[K])
        begin
            prep_den_reg  <= den_next;
            prep_nq1_reg  <= {mag1, {FRAC_BITS{1'b0}}};
            prep_nq2_reg  <= {mag2, {FRAC_BITS{1'b0}}};
            prep_side_reg <= {case_next, neg1_next, neg2_next};
        end
    end

    // Division chain.
    assign d_valid[0] = prep_valid_reg;
    assign d_den[0]   = prep_den_reg;
    assign d_rem1[0]  = '0;
    assign d_rem2[0]  = '0;
    assign d_nq1[0]   = prep_nq1_reg;
    assign d_nq2[0]   = prep_nq2_reg;
    assign d_side[0]  = prep_side_reg;

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        qrs_div_cell #(.NW(NW), .DNW(DNW), .SW(DV_SW)) u_cell
        (
            .clk(clk), .rst_n(rst_n),
            .up_valid(d_valid[k]), .up_stall(d_stall[k]),
            .den_in(d_den[k]), .rem1_in(d_rem1[k]), .rem2_in(d_rem2[k]),
            .nq1_in(d_nq1[k]), .nq2_in(d_nq2[k]), .side_in(d_side[k]),
            .dn_valid(d_valid[k+1]), .dn_stall(d_stall[k+1]),
            .den_out(d_den[k+1]), .rem1_out(d_rem1[k+1]), .rem2_out(d_rem2[k+1]),
            .nq1_out(d_nq1[k+1]), .nq2_out(d_nq2[k+1]), .side_out(d_side[k+1])
        );
    end

    // Result register with clamping to the word range.
    function automatic logic [W:0] clamp_root(input logic [NW-1:0] q, input logic neg);
        logic [W-1:0] lim;
        logic         over;
        logic [W-1:0] mag_v;
        lim   = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        over  = (q[NW-1:W] != '0) || (q[W-1:0] > lim);
        mag_v = over ? lim : q[W-1:0];
        clamp_root = {over, (neg ? -mag_v : mag_v)};
    endfunction

    logic              out_valid_reg;
    logic [2:0]        root_case_reg, f_case;
    logic [W-1:0]      root_one_reg, root_two_reg;
    logic              saturated_reg;
    logic              f_neg1, f_neg2, f_has_root;
    logic [W:0]        f_r1, f_r2;

    assign {f_case, f_neg1, f_neg2} = d_side[NW];
    assign f_r1 = clamp_root(d_nq1[NW], f_neg1);
    assign f_r2 = clamp_root(d_nq2[NW], f_neg2);
    assign f_has_root = (f_case == CASE_LINEAR) || (f_case == CASE_DOUBLE) ||
                        (f_case == CASE_TWO);

    assign d_stall[NW] = out_valid_reg && root_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!d_stall[NW])
        begin
            out_valid_reg <= d_valid[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_valid[NW] && !d_stall[NW])
        begin
            root_case_reg <= f_case;
            root_one_reg  <= f_has_root ? f_r1[W-1:0] : '0;
            root_two_reg  <= f_has_root ? f_r2[W-1:0] : '0;
            saturated_reg <= f_has_root && (f_r1[W] || f_r2[W]);
        end
    end

    assign root_valid = out_valid_reg;
    assign root_case  = root_case_reg;
    assign root_one   = root_one_reg;
    assign root_two   = root_two_reg;
    assign saturated  = saturated_reg;

    logic              out_no_root, out_single_root;

    assign out_no_root     = (root_case == CASE_IDENTITY) ||
                             (root_case == CASE_CONTRADICTION) ||
                             (root_case == CASE_NO_ROOT);
    assign out_single_root = (root_case == CASE_LINEAR) || (root_case == CASE_DOUBLE);

    // A stalled input means every cell down to the result register is occupied.
    `QRS_ASSERT_IMP(a_stall_full, coef_stall, root_valid)
    `QRS_ASSERT_IMP(a_no_root_zero, root_valid && out_no_root, root_one == '0 && root_two == '0 && !saturated)
    `QRS_ASSERT_IMP(a_single_root, root_valid && out_single_root, root_one == root_two)

endmodule
